// File: sv/breakpoint_interval_search_2d_core_macros.svh
// Assertion macros for the breakpoint interval search core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BREAKPOINT_INTERVAL_SEARCH_2D_CORE_MACROS_SVH
`define BREAKPOINT_INTERVAL_SEARCH_2D_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define BISX_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define BISX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bisx_pkg.sv
// Shared constants and types for the breakpoint interval search core.
// No dependencies.
package bisx_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam int MODE_BITS  = 2;
  localparam int SLOT_BITS  = 10;
  localparam int FIELD_BITS = 32;
  localparam int OUT_BITS   = 10;
  localparam int COUNT_BITS = 11;
  localparam int REG_BITS   = 1;

  localparam logic [MODE_BITS-1:0] MODE_LOAD_X = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOAD_Y = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FIND   = 2'd2;

  localparam logic [REG_BITS-1:0] REG_X_COUNT = 1'b0;
  localparam logic [REG_BITS-1:0] REG_Y_COUNT = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [MODE_BITS-1:0] mode;
  } ctl_t;

endpackage

// File: sv/bisx_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module bisx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: sv/bisx_stage.sv
// One bisection step for both axes: private table copies, probe read, compare.
// Depends on bisx_pkg and bisx_ram.
module bisx_stage
  import bisx_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ctl_t                         ctl_i,
  input  logic [SLOT_BITS-1:0]         slot_i,
  input  logic [VALUE_BITS-1:0]        wval_i,
  input  logic signed [FIELD_BITS-1:0] q_i    [2],
  input  logic [AW-1:0]                lo_i   [2],
  input  logic [AW-1:0]                hi_i   [2],
  input  logic [AW-1:0]                res_i  [2],
  input  logic                         done_i [2],
  output ctl_t                         ctl_o,
  output logic [SLOT_BITS-1:0]         slot_o,
  output logic [VALUE_BITS-1:0]        wval_o,
  output logic signed [FIELD_BITS-1:0] q_o    [2],
  output logic [AW-1:0]                lo_o   [2],
  output logic [AW-1:0]                hi_o   [2],
  output logic [AW-1:0]                res_o  [2],
  output logic                         done_o [2]
);

  localparam int CMPW = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  logic [AW-1:0]  mid [2];
  logic           slot_ok;

  // read-side stage
  ctl_t                         ctl_q_r;
  logic [SLOT_BITS-1:0]         slot_q_r;
  logic [VALUE_BITS-1:0]        wval_q_r;
  logic signed [FIELD_BITS-1:0] q_q_r    [2];
  logic [AW-1:0]                lo_q_r   [2];
  logic [AW-1:0]                hi_q_r   [2];
  logic [AW-1:0]                res_q_r  [2];
  logic [AW-1:0]                mid_q_r  [2];
  logic                         done_q_r [2];

  logic [VALUE_BITS-1:0]  d0 [2];
  logic [VALUE_BITS-1:0]  d1 [2];
  logic signed [CMPW-1:0] qv [2];
  logic signed [CMPW-1:0] t0 [2];
  logic signed [CMPW-1:0] t1 [2];

  // compare-side stage
  ctl_t                         ctl_r;
  logic [SLOT_BITS-1:0]         slot_r;
  logic [VALUE_BITS-1:0]        wval_r;
  logic signed [FIELD_BITS-1:0] q_r      [2];
  logic [AW-1:0]                lo_r     [2];
  logic [AW-1:0]                hi_r     [2];
  logic [AW-1:0]                res_r    [2];
  logic                         done_r   [2];
  logic [AW-1:0]                lo_nxt   [2];
  logic [AW-1:0]                hi_nxt   [2];
  logic [AW-1:0]                res_nxt  [2];
  logic                         done_nxt [2];

  assign slot_ok = 32'(slot_i) < 32'(MAX_POINTS);

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic we;

    assign mid[a] = lo_i[a] + ((hi_i[a] - lo_i[a]) >> 1);
    assign we = adv && ctl_i.valid && slot_ok &&
                (ctl_i.mode == ((a == 0) ? MODE_LOAD_X : MODE_LOAD_Y));

    // loads write this copy in step with the finds that read it
    bisx_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(MAX_POINTS)
    ) u_tab (
      .clk    (clk),
      .we     (we),
      .waddr  (AW'(slot_i)),
      .wdata  (wval_i),
      .re     (adv),
      .raddr_a(mid[a]),
      .raddr_b(mid[a] + AW'(1)),
      .rdata_a(d0[a]),
      .rdata_b(d1[a])
    );

    assign qv[a] = CMPW'(q_q_r[a]);
    assign t0[a] = CMPW'($signed(d0[a]));
    assign t1[a] = CMPW'($signed(d1[a]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_q_r.valid <= 1'b0;
      ctl_r.valid   <= 1'b0;
    end else if (adv) begin
      ctl_q_r.valid <= ctl_i.valid;
      ctl_r.valid   <= ctl_q_r.valid;
    end
    if (adv) begin
      ctl_q_r.mode <= ctl_i.mode;
      slot_q_r     <= slot_i;
      wval_q_r     <= wval_i;
      ctl_r.mode   <= ctl_q_r.mode;
      slot_r       <= slot_q_r;
      wval_r       <= wval_q_r;
      for (int a = 0; a < 2; a++) begin
        q_q_r[a]    <= q_i[a];
        lo_q_r[a]   <= lo_i[a];
        hi_q_r[a]   <= hi_i[a];
        res_q_r[a]  <= res_i[a];
        mid_q_r[a]  <= mid[a];
        done_q_r[a] <= done_i[a];
        q_r[a]      <= q_q_r[a];
        lo_r[a]     <= lo_nxt[a];
        hi_r[a]     <= hi_nxt[a];
        res_r[a]    <= res_nxt[a];
        done_r[a]   <= done_nxt[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      lo_nxt[a]   = lo_q_r[a];
      hi_nxt[a]   = hi_q_r[a];
      res_nxt[a]  = res_q_r[a];
      done_nxt[a] = done_q_r[a];
      if (!done_q_r[a]) begin
        if (qv[a] < t0[a]) begin
          if (mid_q_r[a] == lo_q_r[a]) begin
            done_nxt[a] = 1'b1;
            res_nxt[a]  = mid_q_r[a];
          end else begin
            hi_nxt[a] = mid_q_r[a];
          end
        end else if (qv[a] >= t1[a]) begin
          if ((hi_q_r[a] - mid_q_r[a]) <= AW'(1)) begin
            done_nxt[a] = 1'b1;
            res_nxt[a]  = mid_q_r[a];
          end else begin
            lo_nxt[a] = mid_q_r[a] + AW'(1);
          end
        end else begin
          done_nxt[a] = 1'b1;
          res_nxt[a]  = mid_q_r[a];
        end
      end
    end
  end

  assign ctl_o  = ctl_r;
  assign slot_o = slot_r;
  assign wval_o = wval_r;
  assign q_o    = q_r;
  assign lo_o   = lo_r;
  assign hi_o   = hi_r;
  assign res_o  = res_r;
  assign done_o = done_r;

endmodule

// File: sv/breakpoint_interval_search_2d_core.sv
// Top level of the two-axis breakpoint interval search.
// Depends on bisx_pkg, bisx_stage, bisx_ram and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | mode, load_slot, load_value, query_x, query_y
//  out_    | out       | out_valid/out_stall| x_interval, y_interval
//  cfg_    | in        | cfg_valid/ready    | cfg_index, cfg_wdata
//
// One beat enters per cycle while in_stall is low; each find passes through
// every bisection step, and each step is a table read plus a compare.
// Every step owns copies of both tables; loads walk the pipe and write each copy.
// A stalled result freezes the whole pipe, and in_stall follows it.
// Reset clears valid bits and counts only; tables hold garbage until loaded.
`include "breakpoint_interval_search_2d_core_macros.svh"

module breakpoint_interval_search_2d_core
  import bisx_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [MODE_BITS-1:0]         in_mode,
  input  logic [SLOT_BITS-1:0]         in_load_slot,
  input  logic signed [FIELD_BITS-1:0] in_load_value,
  input  logic signed [FIELD_BITS-1:0] in_query_x,
  input  logic signed [FIELD_BITS-1:0] in_query_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [OUT_BITS-1:0]          out_x_interval,
  output logic [OUT_BITS-1:0]          out_y_interval,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [REG_BITS-1:0]          cfg_index,
  input  logic [COUNT_BITS-1:0]        cfg_wdata
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = AW + 1;
  localparam int NSTG = AW + 1;

  logic [COUNT_BITS-1:0] x_count_r;
  logic [COUNT_BITS-1:0] y_count_r;
  logic                  adv;

  ctl_t                         ctl_c  [NSTG+1];
  logic [SLOT_BITS-1:0]         slot_c [NSTG+1];
  logic [VALUE_BITS-1:0]        wval_c [NSTG+1];
  logic signed [FIELD_BITS-1:0] q_c    [NSTG+1][2];
  logic [AW-1:0]                lo_c   [NSTG+1][2];
  logic [AW-1:0]                hi_c   [NSTG+1][2];
  logic [AW-1:0]                res_c  [NSTG+1][2];
  logic                         done_c [NSTG+1][2];
  logic [CW-1:0]                cnt    [2];
  logic [COUNT_BITS-1:0]        cnt_raw [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_count_r <= '0;
      y_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_COUNT: x_count_r <= cfg_wdata;
        REG_Y_COUNT: y_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign cnt_raw[0] = x_count_r;
  assign cnt_raw[1] = y_count_r;

  // seed the search range; small tables answer zero at once
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (32'(cnt_raw[a]) > 32'(MAX_POINTS)) begin
        cnt[a] = CW'(MAX_POINTS);
      end else begin
        cnt[a] = CW'(cnt_raw[a]);
      end
      lo_c[0][a]   = '0;
      hi_c[0][a]   = AW'(cnt[a] - CW'(1));
      res_c[0][a]  = '0;
      done_c[0][a] = cnt[a] <= CW'(1);
    end
  end

  assign ctl_c[0].valid = in_valid;
  assign ctl_c[0].mode  = in_mode;
  assign slot_c[0]      = in_load_slot;
  assign wval_c[0]      = VALUE_BITS'(in_load_value);
  assign q_c[0][0]      = in_query_x;
  assign q_c[0][1]      = in_query_y;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    bisx_stage #(
      .MAX_POINTS(MAX_POINTS),
      .VALUE_BITS(VALUE_BITS)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_c[k]),
      .slot_i(slot_c[k]),
      .wval_i(wval_c[k]),
      .q_i   (q_c[k]),
      .lo_i  (lo_c[k]),
      .hi_i  (hi_c[k]),
      .res_i (res_c[k]),
      .done_i(done_c[k]),
      .ctl_o (ctl_c[k+1]),
      .slot_o(slot_c[k+1]),
      .wval_o(wval_c[k+1]),
      .q_o   (q_c[k+1]),
      .lo_o  (lo_c[k+1]),
      .hi_o  (hi_c[k+1]),
      .res_o (res_c[k+1]),
      .done_o(done_c[k+1])
    );
  end

  // loads and unused modes drop out here
  assign out_valid      = ctl_c[NSTG].valid && (ctl_c[NSTG].mode == MODE_FIND);
  assign out_x_interval = OUT_BITS'(res_c[NSTG][0]);
  assign out_y_interval = OUT_BITS'(res_c[NSTG][1]);

  `BISX_ASSERT_IMPLY(a_x_done, out_valid, done_c[NSTG][0], "x search unfinished at output")
  `BISX_ASSERT_IMPLY(a_y_done, out_valid, done_c[NSTG][1], "y search unfinished at output")
  `BISX_ASSERT_NEXT(a_rst_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for breakpoint_interval_search_2d_core: a directed table, then
// random load/find phases checked against an in-bench interval search over shadow tables.
// Depends on bisx_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import bisx_pkg::*;

  localparam int NPTS = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         mode;
    logic [9:0]         slot;
    logic signed [31:0] val;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    bit                 typed;
    logic [9:0]         ex;
    logic [9:0]         ey;
  } stim_row_t;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
  } interval_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_BITS-1:0] in_mode = '0;
  logic [SLOT_BITS-1:0] in_load_slot = '0;
  logic signed [FIELD_BITS-1:0] in_load_value = '0;
  logic signed [FIELD_BITS-1:0] in_query_x = '0;
  logic signed [FIELD_BITS-1:0] in_query_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_BITS-1:0] out_x_interval;
  logic [OUT_BITS-1:0] out_y_interval;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_BITS-1:0] cfg_index = '0;
  logic [COUNT_BITS-1:0] cfg_wdata = '0;

  breakpoint_interval_search_2d_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the block
  logic signed [31:0] x_tab [NPTS];
  logic signed [31:0] y_tab [NPTS];
  logic [10:0] x_count = '0;
  logic [10:0] y_count = '0;

  interval_pair_t pending_q[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  function automatic logic [9:0] search_interval(input bit y_axis, input logic [10:0] cnt,
                                                 input logic signed [31:0] v);
    int n, lo, hi, mid;
    logic signed [31:0] b0, b1;
    n = (cnt > NPTS) ? NPTS : cnt;
    if (n <= 1) return '0;
    lo = 0;
    hi = n - 1;
    forever begin
      mid = lo + (hi - lo) / 2;
      b0 = y_axis ? y_tab[mid] : x_tab[mid];
      b1 = y_axis ? y_tab[mid+1] : x_tab[mid+1];
      if (v < b0) begin
        if (mid == lo) return mid[9:0];
        hi = mid;
      end else if (v >= b1) begin
        if (hi - mid <= 1) return mid[9:0];
        lo = mid + 1;
      end else begin
        return mid[9:0];
      end
    end
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [9:0] slot,
                           input logic signed [31:0] val, input logic signed [31:0] qx,
                           input logic signed [31:0] qy, input bit typed,
                           input logic [9:0] ex, input logic [9:0] ey);
    interval_pair_t e;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_load_slot = slot;
    in_load_value = val;
    in_query_x = qx;
    in_query_y = qy;
    do @(posedge clk); while (in_stall);
    // beat accepted: advance the shadow state
    case (mode)
      MODE_LOAD_X: x_tab[slot] = val;
      MODE_LOAD_Y: y_tab[slot] = val;
      MODE_FIND: begin
        if (typed) begin
          e.x = ex;
          e.y = ey;
        end else begin
          e.x = search_interval(1'b0, x_count, qx);
          e.y = search_interval(1'b1, y_count, qy);
        end
        pending_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_BITS-1:0] idx, input logic [10:0] data);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_X_COUNT) x_count = data;
    else y_count = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    interval_pair_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat x=%0d y=%0d", out_x_interval, out_y_interval);
      end else begin
        e = pending_q.pop_front();
        if (out_x_interval !== e.x || out_y_interval !== e.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     e.x, e.y, out_x_interval, out_y_interval);
        end
      end
    end
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_query(input bit y_axis, input logic [10:0] cnt);
    int n, i;
    logic signed [31:0] b;
    n = (cnt > NPTS) ? NPTS : cnt;
    case ($urandom_range(0, 9))
      0: return VMIN;
      1: return VMAX;
      2, 3: return $urandom;
      default: begin
        if (n == 0) return $urandom;
        i = $urandom_range(0, n - 1);
        b = y_axis ? y_tab[i] : x_tab[i];
        return b + $signed($urandom_range(0, 2)) - 32'sd1;
      end
    endcase
  endfunction

  task automatic load_sorted(input bit y_axis, input int n, input bit scramble);
    int vals[$];
    for (int i = 0; i < n; i++) vals.push_back($urandom);
    if (!scramble) vals.sort();
    for (int i = 0; i < n; i++)
      send_item(y_axis ? MODE_LOAD_Y : MODE_LOAD_X, i[9:0], vals[i], $urandom, $urandom,
                1'b0, '0, '0);
  endtask

  // counts past n only where the whole table has been written
  function automatic logic [10:0] pick_count(input int n, input bit full);
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd2;
      3: return full ? 11'd1024 : n[10:0];
      4: return full ? 11'd2047 : n[10:0];
      5: return full ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(0, n));
      default: return n[10:0];
    endcase
  endfunction

  stim_row_t directed[$];

  function automatic stim_row_t item_row(input logic [1:0] mode, input logic [9:0] slot,
                                         input logic signed [31:0] val,
                                         input logic signed [31:0] qx,
                                         input logic signed [31:0] qy, input bit typed,
                                         input logic [9:0] ex, input logic [9:0] ey);
    stim_row_t r;
    r = '{ROW_ITEM, mode, slot, val, qx, qy, typed, ex, ey};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [REG_BITS-1:0] idx, input logic [10:0] c);
    stim_row_t r;
    r = '{ROW_CFG, '0, {9'd0, idx}, {21'd0, c}, 0, 0, 1'b0, '0, '0};
    return r;
  endfunction

  initial begin
    int phases, n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty tables: any query lands in interval 0
    directed.push_back(item_row(MODE_FIND, 0, 0, VMIN, VMIN, 1'b1, 0, 0));
    directed.push_back(item_row(MODE_FIND, 0, 0, VMAX, VMAX, 1'b1, 0, 0));
    directed.push_back(item_row(MODE_UNUSED, 10'h3ff, VMAX, VMAX, VMIN, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_X, 0, -32'sd100, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_X, 1, 32'sd0, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_X, 2, 32'sd100, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_X, 3, 32'sd200, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_Y, 0, VMIN, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_Y, 1, -32'sd1, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_Y, 2, 32'sd1, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_Y, 3, VMAX, 0, 0, 1'b0, 0, 0));
    directed.push_back(cfg_row(REG_X_COUNT, 11'd1));
    directed.push_back(cfg_row(REG_Y_COUNT, 11'd1));
    directed.push_back(item_row(MODE_FIND, 0, 0, VMAX, VMIN, 1'b1, 0, 0));
    directed.push_back(cfg_row(REG_X_COUNT, 11'd4));
    directed.push_back(cfg_row(REG_Y_COUNT, 11'd4));
    directed.push_back(item_row(MODE_FIND, 0, 0, VMIN, VMIN, 1'b1, 0, 0));
    directed.push_back(item_row(MODE_FIND, 0, 0, VMAX, VMAX, 1'b1, 2, 2));
    directed.push_back(item_row(MODE_FIND, 0, 0, 32'sd0, -32'sd1, 1'b1, 1, 1));
    directed.push_back(item_row(MODE_FIND, 0, 0, 32'sd100, 32'sd0, 1'b1, 2, 1));
    directed.push_back(item_row(MODE_FIND, 0, 0, -32'sd101, 32'sd1, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_FIND, 0, 0, 32'sd199, -32'sd2, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_LOAD_X, 2, -32'sd500, 0, 0, 1'b0, 0, 0));
    directed.push_back(item_row(MODE_FIND, 0, 0, 32'sd50, 32'sd5, 1'b0, 0, 0));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].slot[REG_BITS-1:0], directed[i].val[10:0]);
      else
        send_item(directed[i].mode, directed[i].slot, directed[i].val, directed[i].qx,
                  directed[i].qy, directed[i].typed, directed[i].ex, directed[i].ey);
    end

    // fill the X table completely so any X count is legal from here on;
    // Y counts stay within the rows loaded in each phase
    load_sorted(1'b0, NPTS, 1'b0);

    phases = 10;
    for (int p = 0; p < phases; p++) begin
      if (p >= phases - 3) quiet = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 16);
      load_sorted(1'b0, n, $urandom_range(0, 9) == 0);
      load_sorted(1'b1, n, $urandom_range(0, 9) == 0);
      write_reg(REG_X_COUNT, pick_count(n, 1'b1));
      write_reg(REG_Y_COUNT, pick_count(n, 1'b0));
      repeat ($urandom_range(15, 35)) begin
        case ($urandom_range(0, 19))
          0: send_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0, '0, '0);
          1: send_item(MODE_LOAD_X, $urandom, $urandom, $urandom, $urandom, 1'b0, '0, '0);
          2: send_item(MODE_LOAD_Y, $urandom, $urandom, $urandom, $urandom, 1'b0, '0, '0);
          default: send_item(MODE_FIND, $urandom, $urandom, pick_query(1'b0, x_count),
                             pick_query(1'b1, y_count), 1'b0, '0, '0);
        endcase
      end
    end

    drain();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: breakpoint_interval_search_2d_core.f
+incdir+sv
sv/bisx_pkg.sv
sv/bisx_ram.sv
sv/bisx_stage.sv
sv/breakpoint_interval_search_2d_core.sv
verif/testbench.sv
